// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// condition holds at every clock edge out of reset
`define PMD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define PMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PMD_ASSERT(lbl, cond, msg)
`define PMD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg
// Types, constants and helper functions of the mouse packet decoder.
// ----------------------------------------------------------------------------
package pmd_pkg;

  localparam int COORD_BITS    = 12;
  localparam int SCREEN_W      = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int COORD_MAX_INT = (1 << COORD_BITS) - 1;
  localparam int LIM_W         = (COORD_BITS > SCREEN_W) ? COORD_BITS : SCREEN_W;
  localparam int SUM_W         = COORD_BITS + 2;

  localparam int OUT_FIELDS_W  = 8 + 8 + 3 + 2 + 2 * COORD_BITS;
  localparam int OUT_W         = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [7:0] HEADER_SYNC_BIT = 8'h08;
  localparam logic [2:0] BUTTON_MASK     = 3'h7;
  localparam logic [3:0] NIBBLE_MASK     = 4'hF;
  localparam logic [3:0] NIBBLE_UP       = 4'h1;

  localparam logic [1:0] WHEEL_PACKET_LEN = 2'd3;  // last position, four bytes
  localparam logic [1:0] BASIC_PACKET_LEN = 2'd2;  // last position, three bytes

  localparam logic [1:0] WHEEL_NONE = 2'b00;
  localparam logic [1:0] WHEEL_UP   = 2'b01;
  localparam logic [1:0] WHEEL_DOWN = 2'b11;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SCREEN_W-1:0]   screen_t;

  localparam coord_t COORD_MAX = coord_t'(COORD_MAX_INT);
  localparam coord_t X_RESET   = coord_t'((320 > COORD_MAX_INT) ? COORD_MAX_INT : 320);
  localparam coord_t Y_RESET   = coord_t'((240 > COORD_MAX_INT) ? COORD_MAX_INT : 240);

  localparam screen_t WIDTH_RESET  = screen_t'(640);
  localparam screen_t HEIGHT_RESET = screen_t'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic   wheel_en;
    coord_t x_lim;
    coord_t y_lim;
  } cfg_t;

  typedef struct packed {
    logic       done;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [2:0] buttons;
    logic [1:0] wheel;
  } packet_t;

  function automatic coord_t upper_limit(input screen_t size);
    screen_t size_m1;
    coord_t  lim;
    size_m1 = size - screen_t'(1);
    if (size == '0) begin
      lim = '0;
    end else if (LIM_W'(size_m1) > LIM_W'(COORD_MAX)) begin
      lim = COORD_MAX;
    end else begin
      lim = coord_t'(size_m1);
    end
    return lim;
  endfunction

  function automatic coord_t clamp_pos(input logic signed [SUM_W-1:0] v, input coord_t lim);
    coord_t res;
    if (v[SUM_W-1]) begin
      res = '0;
    end else if (v[COORD_BITS:0] > {1'b0, lim}) begin
      res = lim;
    end else begin
      res = v[COORD_BITS-1:0];
    end
    return res;
  endfunction

endpackage

// File: sv/pmd_cfg_regs.sv
// ----------------------------------------------------------------------------
// pmd_cfg_regs
// Configuration registers and the cursor limits derived from them.
// ----------------------------------------------------------------------------
module pmd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pmd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pmd_pkg::SCREEN_W-1:0]  cfg_data_i,
  output pmd_pkg::cfg_t                 cfg_o
);
  import pmd_pkg::*;

  logic    wheel_q, wheel_d;
  screen_t width_q, width_d;
  screen_t height_q, height_d;
  logic    wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i;

  always_comb begin
    wheel_d  = wheel_q;
    width_d  = width_q;
    height_d = height_q;
    if (wr) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WHEEL:  wheel_d  = cfg_data_i[0];
        CFG_WIDTH:  width_d  = cfg_data_i;
        CFG_HEIGHT: height_d = cfg_data_i;
        default: begin
          wheel_d = wheel_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q  <= 1'b0;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else begin
      wheel_q  <= wheel_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign cfg_o.wheel_en = wheel_q;
  assign cfg_o.x_lim    = upper_limit(width_q);
  assign cfg_o.y_lim    = upper_limit(height_q);

endmodule

// File: sv/pmd_assembler.sv
// ----------------------------------------------------------------------------
// pmd_assembler
// Header sync, byte position tracking and packet field decode.
// ----------------------------------------------------------------------------
module pmd_assembler (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  input  logic             wheel_en_i,
  output pmd_pkg::packet_t pkt_o
);
  import pmd_pkg::*;

  `include "assert_macros.svh"

  logic [1:0] pos_q, pos_d;
  logic [7:0] store_q [3];
  logic [1:0] last_pos;
  logic       drop;
  logic       done;

  assign last_pos = wheel_en_i ? WHEEL_PACKET_LEN : BASIC_PACKET_LEN;
  assign drop     = (pos_q == 2'd0) && ((byte_i & HEADER_SYNC_BIT) == '0);
  assign done     = !drop && (pos_q >= last_pos);

  always_comb begin
    pos_d = pos_q;
    if (fire_i && !drop) begin
      pos_d = done ? 2'd0 : pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && !drop && pos_q != 2'd3) begin
      store_q[pos_q] <= byte_i;
    end
  end

  always_comb begin
    pkt_o.done    = done;
    pkt_o.dx      = store_q[1];
    pkt_o.dy      = (pos_q == 2'd2) ? byte_i : store_q[2];
    pkt_o.buttons = store_q[0][2:0] & BUTTON_MASK;
    pkt_o.wheel   = WHEEL_NONE;
    if (wheel_en_i && pos_q == 2'd3) begin
      if ((byte_i[3:0] & NIBBLE_MASK) == NIBBLE_UP) begin
        pkt_o.wheel = WHEEL_UP;
      end else if ((byte_i[3:0] & NIBBLE_MASK) == NIBBLE_MASK) begin
        pkt_o.wheel = WHEEL_DOWN;
      end
    end
  end

  `PMD_ASSERT_NEXT(a_done_restarts, fire_i && done, pos_q == 2'd0, "packet end must restart")
  `PMD_ASSERT_NEXT(a_drop_holds, fire_i && drop, pos_q == 2'd0, "unsynced byte must drop")
  `PMD_ASSERT_NEXT(a_hold_idle, !fire_i, $stable(pos_q), "position moved without item")

endmodule

// File: sv/pmd_cursor.sv
// ----------------------------------------------------------------------------
// pmd_cursor
// Cursor position tracking with clamping, and the result register.
// ----------------------------------------------------------------------------
module pmd_cursor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  pmd_pkg::packet_t          pkt_i,
  input  pmd_pkg::cfg_t             cfg_i,
  output logic                      ready_o,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [pmd_pkg::OUT_W-1:0] m_axis_tdata
);
  import pmd_pkg::*;

  `include "assert_macros.svh"

  coord_t x_q, x_d;
  coord_t y_q, y_d;
  logic   valid_q, valid_d;
  logic [OUT_FIELDS_W-1:0] res_q, res_d;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic   emit;

  assign emit    = fire_i && pkt_i.done;
  assign ready_o = !valid_q || m_axis_tready;

  assign sum_x = $signed({2'b00, x_q}) + $signed({{(SUM_W-8){pkt_i.dx[7]}}, pkt_i.dx});
  assign sum_y = $signed({2'b00, y_q}) - $signed({{(SUM_W-8){pkt_i.dy[7]}}, pkt_i.dy});

  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    res_d   = res_q;
    valid_d = valid_q;
    if (m_axis_tready) begin
      valid_d = 1'b0;
    end
    if (emit) begin
      x_d     = clamp_pos(sum_x, cfg_i.x_lim);
      y_d     = clamp_pos(sum_y, cfg_i.y_lim);
      res_d   = {y_d, x_d, pkt_i.wheel, pkt_i.buttons, pkt_i.dy, pkt_i.dx};
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q     <= X_RESET;
      y_q     <= Y_RESET;
      valid_q <= 1'b0;
    end else begin
      x_q     <= x_d;
      y_q     <= y_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(OUT_W-OUT_FIELDS_W){1'b0}}, res_q};

  `PMD_ASSERT_NEXT(a_emit_valid, emit, valid_q, "completed packet must show a result")
  `PMD_ASSERT_NEXT(a_stall_keeps, valid_q && !m_axis_tready, valid_q, "result lost on stall")
  `PMD_ASSERT(a_no_fire_stalled, !(fire_i && !ready_o), "item processed into full result")
  `PMD_ASSERT_NEXT(a_pos_hold, !emit, $stable(x_q) && $stable(y_q), "cursor moved idle")

endmodule

// File: sv/ps2_mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// Mouse byte stream to decoded packets with a clamped cursor position.
// ----------------------------------------------------------------------------
// Takes one mouse byte per clock cycle while the result stream is not
// stalled. A byte passes an input register, then the header check, packet
// decode and cursor add-and-clamp run combinationally into the result
// register. The last byte of a packet passes the input register and then
// the result register, which offers its item. A stalled result holds the
// input register and so the input. The cursor update is a feedback path
// through the cursor registers. Bytes with bit 3 clear are dropped while
// waiting for a packet header. Packets are three bytes, or four with wheel
// mode on. Write configuration only while no item is in flight.
module ps2_mouse_packet_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pmd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pmd_pkg::SCREEN_W-1:0]  cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] delta_x, [15:8] delta_y, [18:16] button_bits, [20:19] wheel_step,
  // then cursor_x, cursor_y, zero fill
  output logic [pmd_pkg::OUT_W-1:0]     m_axis_tdata
);
  import pmd_pkg::*;

  cfg_t       cfg;
  packet_t    pkt;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_ready;
  logic       fire;
  logic       take;

  assign fire          = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  pmd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pmd_assembler u_asm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (in_byte_q),
    .wheel_en_i (cfg.wheel_en),
    .pkt_o      (pkt)
  );

  pmd_cursor u_cursor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .pkt_i         (pkt),
    .cfg_i         (cfg),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mouse packet decoder: drives mouse bytes and
// register writes, predicts each decoded packet and cursor position, and
// compares every result item field by field, with and without random stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB            = pmd_pkg::COORD_BITS;
  localparam int CW            = pmd_pkg::SCREEN_W;
  localparam int COORD_TOP     = (1 << CB) - 1;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [7:0] SYNC_BIT  = 8'h08;
  localparam logic [3:0] NIB_UP    = 4'h1;
  localparam logic [3:0] NIB_DOWN  = 4'hF;
  localparam logic [1:0] STEP_NONE = 2'b00;
  localparam logic [1:0] STEP_UP   = 2'b01;
  localparam logic [1:0] STEP_DOWN = 2'b11;

  typedef struct {
    logic [7:0]    dx;
    logic [7:0]    dy;
    logic [2:0]    buttons;
    logic [1:0]    wheel;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
  } mouse_report_t;

  class cursor_tracker;
    bit            wheel_on;
    logic [CW-1:0] width;
    logic [CW-1:0] height;
    int unsigned   slot;
    logic [7:0]    pkt[3];
    int            x_pos;
    int            y_pos;
    mouse_report_t pending_reports[$];
    int            errors;

    function new();
      wheel_on = 1'b0;
      width    = CW'(640);
      height   = CW'(480);
      slot     = 0;
      x_pos    = (320 > COORD_TOP) ? COORD_TOP : 320;
      y_pos    = (240 > COORD_TOP) ? COORD_TOP : 240;
      errors   = 0;
    endfunction

    function void set_reg(pmd_pkg::cfg_idx_e idx, logic [CW-1:0] val);
      case (idx)
        pmd_pkg::CFG_WHEEL:  wheel_on = val[0];
        pmd_pkg::CFG_WIDTH:  width    = val;
        pmd_pkg::CFG_HEIGHT: height   = val;
        default: ;
      endcase
    endfunction

    function int ceiling(logic [CW-1:0] size);
      if (size == '0) return 0;
      if (int'(size) - 1 > COORD_TOP) return COORD_TOP;
      return int'(size) - 1;
    endfunction

    function int fit(int v, int lim);
      if (v < 0) return 0;
      if (v > lim) return lim;
      return v;
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned   last;
      int            dx;
      int            dy;
      mouse_report_t r;
      last = wheel_on ? 3 : 2;
      if (slot == 0 && (b & SYNC_BIT) == 8'h00) return;
      if (slot < 3) pkt[slot] = b;
      if (slot < last) begin
        slot++;
        return;
      end
      r.wheel = STEP_NONE;
      if (wheel_on && slot == 3) begin
        if (b[3:0] == NIB_UP) r.wheel = STEP_UP;
        else if (b[3:0] == NIB_DOWN) r.wheel = STEP_DOWN;
      end
      slot = 0;
      dx = int'($signed(pkt[1]));
      dy = int'($signed(pkt[2]));
      x_pos = fit(x_pos + dx, ceiling(width));
      y_pos = fit(y_pos - dy, ceiling(height));
      r.dx      = pkt[1];
      r.dy      = pkt[2];
      r.buttons = pkt[0][2:0];
      r.cx      = x_pos[CB-1:0];
      r.cy      = y_pos[CB-1:0];
      pending_reports.push_back(r);
    endfunction

    function void check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
      end
    endfunction

    function void match_report(logic [pmd_pkg::OUT_W-1:0] d);
      mouse_report_t e;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: result item expected none, got %h", $time, d);
        return;
      end
      e = pending_reports.pop_front();
      check_field("delta_x", int'(e.dx), int'(d[7:0]));
      check_field("delta_y", int'(e.dy), int'(d[15:8]));
      check_field("button_bits", int'(e.buttons), int'(d[18:16]));
      check_field("wheel_step", int'(e.wheel), int'(d[20:19]));
      check_field("cursor_x", int'(e.cx), int'(d[21 +: CB]));
      check_field("cursor_y", int'(e.cy), int'(d[21 + CB +: CB]));
    endfunction
  endclass

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [pmd_pkg::CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [CW-1:0]                cfg_data_i    = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [pmd_pkg::OUT_W-1:0]    m_axis_tdata;

  cursor_tracker tracker;
  int            src_idle_pct   = 0;
  int            sink_stall_pct = 0;
  int            bytes_sent     = 0;
  int            cycle_count    = 0;

  logic [7:0] opening[17] = '{8'h00, 8'hF7, 8'h0F, 8'h7F, 8'h80, 8'h01,
                              8'h08, 8'h80, 8'h7F, 8'h0F, 8'hFF, 8'h00,
                              8'h00, 8'hF5, 8'h09, 8'h10, 8'h20};

  ps2_mouse_packet_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ps2_mouse_packet_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) tracker.match_report(m_axis_tdata);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  task automatic write_reg(input pmd_pkg::cfg_idx_e idx, input logic [CW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, val);
  endtask

  task automatic configure(input bit wheel, input int w, input int h);
    write_reg(pmd_pkg::CFG_WHEEL, CW'(wheel));
    write_reg(pmd_pkg::CFG_WIDTH, CW'(w));
    write_reg(pmd_pkg::CFG_HEIGHT, CW'(h));
    cfg_valid_i <= 1'b0;
  endtask

  // drain every pending result, then give the pipeline time to empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_packet();
    logic [7:0] b;
    b    = 8'($urandom);
    b[3] = 1'b1;
    send_byte(b);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    if (tracker.wheel_on) begin
      b = 8'($urandom);
      case ($urandom_range(2))
        0: b[3:0] = NIB_UP;
        1: b[3:0] = NIB_DOWN;
        default: ;
      endcase
      send_byte(b);
    end
  endtask

  function automatic int pick_size();
    case ($urandom_range(3))
      0: return 1;
      1: return 4096;
      2: return int'($urandom_range(4096, 1));
      default: return int'($urandom_range(64, 1));
    endcase
  endfunction

  initial begin
    int phase_start;
    tracker = new();
    do @(posedge clk_i); while (!rst_ni);

    configure(1'b1, 640, 480);
    foreach (opening[i]) send_byte(opening[i]);
    settle();
    // leftover fourth byte closes the packet in three-byte mode
    configure(1'b0, 640, 480);
    send_byte(8'hAA);
    send_byte(8'h0C);
    send_byte(8'h55);
    settle();
    configure(1'b1, 640, 480);
    send_byte(8'h33);
    send_byte(8'h0F);
    settle();
    configure(1'b1, 1, 1);
    send_byte(8'h0C);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'h01);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      configure(1'($urandom_range(1)), pick_size(), pick_size());
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
        default: begin src_idle_pct = 28; sink_stall_pct = 28; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 50) begin
        if ($urandom_range(99) < 85) send_packet();
        else send_byte(8'($urandom));
      end
    end

    settle();
    if (tracker.errors == 0) begin
      $display("ps2_mouse_packet_decoder regression: pass");
    end else begin
      $display("ps2_mouse_packet_decoder regression: fail");
    end
    $finish;
  end

endmodule
